FILE: rtl/gsba_pkg.sv
package gsba_pkg;

  localparam int unsigned NumWordsDef = 32;
  localparam int unsigned WordBitsLog = 5;

  localparam int unsigned TexW     = 15;
  localparam int unsigned SlotNumW = 10;
  localparam int unsigned PosW     = 24;
  localparam int unsigned PerRowW  = 11;
  localparam int unsigned SlotDimW = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [PerRowW-1:0]  PerRowRst  = 11'd16;
  localparam logic [SlotDimW-1:0] SlotDimRst = 13'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOTS_PER_ROW = 2'd0,
    CFG_SLOT_WIDTH    = 2'd1,
    CFG_SLOT_HEIGHT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/grid_slot_bitmap_allocator.sv
// an accepted beat passes through the division, multiply and done states to the result register;
// when the atlas is full it goes straight to done; the divider takes one quotient bit per cycle
// a new request is taken only once the previous result is loaded into the output register;
// a stalled result holding the output register delays the next request
// reset: asynchronous, active low; all slots free, slots_per_row 16, slot size 64 x 64
module grid_slot_bitmap_allocator
  import gsba_pkg::*;
#(
  parameter int unsigned NUM_WORDS = NumWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // tex_width, tex_height, zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [87:0]         m_axis_tdata,  // slot_number, pos_x, pos_y, dim_width, dim_height
  output logic [0:0]          m_axis_tuser,  // full_res
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SlotW = $clog2(NUM_WORDS) + WordBitsLog;

  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic [SlotNumW-1:0] slot_number;
  logic [PosW-1:0]     pos_x, pos_y;
  logic [TexW-1:0]     dim_width, dim_height;
  logic                full_res;
  logic [SlotW:0]      fill;

  gsba_ctrl #(.NUM_WORDS(NUM_WORDS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gsba_dp #(.NUM_WORDS(NUM_WORDS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .tex_width_i   (s_axis_tdata[14:0]),
    .tex_height_i  (s_axis_tdata[29:15]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .slot_number_o (slot_number),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .dim_width_o   (dim_width),
    .dim_height_o  (dim_height),
    .full_res_o    (full_res),
    .fill_o        (fill)
  );

  assign m_axis_tdata = {dim_height, dim_width, pos_y, pos_x, slot_number};
  assign m_axis_tuser = full_res;

  // a full result carries no slot and no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[57:0] == 58'd0)
    else $error("full result with nonzero slot fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= (SlotW+1)'(NUM_WORDS << WordBitsLog))
    else $error("fill level beyond slot count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !status.full |=> fill == $past(fill) + (SlotW+1)'(1))
    else $error("claimed slot not recorded");

endmodule

FILE: rtl/gsba_ctrl.sv
module gsba_ctrl
  import gsba_pkg::*;
#(
  parameter int unsigned NUM_WORDS = NumWordsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam int unsigned SlotW = $clog2(NUM_WORDS) + WordBitsLog;
  localparam int unsigned CntW  = $clog2(SlotW);

  state_e          state_q, state_d;
  logic [CntW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          // a full atlas needs no coordinates
          state_d    = status_i.full ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + CntW'(1);
        if (step_q == CntW'(SlotW - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/gsba_dp.sv
module gsba_dp
  import gsba_pkg::*;
#(
  parameter int unsigned NUM_WORDS = NumWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [TexW-1:0]     tex_width_i,
  input  logic [TexW-1:0]     tex_height_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SlotNumW-1:0] slot_number_o,
  output logic [PosW-1:0]     pos_x_o,
  output logic [PosW-1:0]     pos_y_o,
  output logic [TexW-1:0]     dim_width_o,
  output logic [TexW-1:0]     dim_height_o,
  output logic                full_res_o,
  output logic [$clog2(NUM_WORDS)+WordBitsLog:0] fill_o
);

  localparam int unsigned SlotW    = $clog2(NUM_WORDS) + WordBitsLog;
  localparam int unsigned MaxSlots = NUM_WORDS << WordBitsLog;

  // slots are claimed strictly in order and never freed, so the bitmap is
  // all ones below the fill level and all zeros above it
  logic [SlotW:0]         fill_q;
  logic [PerRowW-1:0]     per_row_q;
  logic [SlotDimW-1:0]    slot_w_q, slot_h_q;
  logic                   full_q;
  logic [SlotW-1:0]       slot_q, quot_q;
  logic [PerRowW-1:0]     rem_q;
  logic [TexW-1:0]        tw_q, th_q;
  logic [PosW-1:0]        px_q, py_q;
  logic                   out_valid_q;
  logic [SlotNumW-1:0]    o_slot_q;
  logic [PosW-1:0]        o_px_q, o_py_q;
  logic [TexW-1:0]        o_tw_q, o_th_q;
  logic                   o_full_q;

  logic                   atlas_full;
  logic [PerRowW-1:0]     divisor;
  logic [PerRowW:0]       rem_sh;
  logic                   q_bit;
  logic [PosW-1:0]        col_prod;
  logic [SlotW+SlotDimW-1:0] row_prod;
  logic [SlotW+SlotDimW+PosW-1:0] row_ext;
  logic [SlotW+SlotNumW-1:0] slot_ext;

  assign atlas_full = (fill_q == (SlotW+1)'(MaxSlots));
  assign divisor    = (per_row_q == '0) ? PerRowW'(1) : per_row_q;
  assign rem_sh     = {rem_q, quot_q[SlotW-1]};
  assign q_bit      = (rem_sh >= {1'b0, divisor});
  assign col_prod   = PosW'(rem_q) * PosW'(slot_w_q);
  assign row_prod   = (SlotW+SlotDimW)'(quot_q) * (SlotW+SlotDimW)'(slot_h_q);
  assign row_ext    = {{PosW{1'b0}}, row_prod};
  assign slot_ext   = {{SlotNumW{1'b0}}, slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      per_row_q   <= PerRowRst;
      slot_w_q    <= SlotDimRst;
      slot_h_q    <= SlotDimRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SLOTS_PER_ROW: per_row_q <= cfg_data_i[PerRowW-1:0];
          CFG_SLOT_WIDTH:    slot_w_q  <= cfg_data_i;
          CFG_SLOT_HEIGHT:   slot_h_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && !atlas_full) begin
        fill_q <= fill_q + (SlotW+1)'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      full_q <= atlas_full;
      slot_q <= fill_q[SlotW-1:0];
      quot_q <= fill_q[SlotW-1:0];
      rem_q  <= '0;
      tw_q   <= tex_width_i;
      th_q   <= tex_height_i;
    end
    // restoring divide, one quotient bit per beat
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? PerRowW'(rem_sh - {1'b0, divisor}) : rem_sh[PerRowW-1:0];
      quot_q <= {quot_q[SlotW-2:0], q_bit};
    end
    if (cmd_i.mul) begin
      px_q <= col_prod;
      py_q <= row_ext[PosW-1:0];
    end
    if (cmd_i.out_load) begin
      o_full_q <= full_q;
      o_tw_q   <= tw_q;
      o_th_q   <= th_q;
      o_slot_q <= full_q ? '0 : slot_ext[SlotNumW-1:0];
      o_px_q   <= full_q ? '0 : px_q;
      o_py_q   <= full_q ? '0 : py_q;
    end
  end

  assign status_o.full     = atlas_full;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign slot_number_o = o_slot_q;
  assign pos_x_o       = o_px_q;
  assign pos_y_o       = o_py_q;
  assign dim_width_o   = o_tw_q;
  assign dim_height_o  = o_th_q;
  assign full_res_o    = o_full_q;
  assign fill_o        = fill_q;

endmodule
